>>> rtl/core/mbp_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer: shared package
// Item kind codes, field widths and the structs passed between the field
// sequencer and the byte accumulator.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned WIDTH_W = 6;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CAP_W   = 25;
    localparam int unsigned BITS_W  = 7;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ESCAPE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALIGN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESET  = 2'd3;

    localparam logic [WIDTH_W-1:0] MAX_FIELD_W = 6'd32;
    localparam logic [3:0]         BYTE_BITS   = 4'd8;

    // One token from the sequencer: a single stream bit or the end of an item.
    typedef struct packed {
        logic valid;
        logic is_end;
        logic clear;
        logic data_bit;
    } mbp_token_t;

    // Accumulator state seen by the sequencer.
    typedef struct packed {
        logic tok_ready;
        logic aligned;
    } mbp_acc_status_t;

    // Field widths above 32 act as 32.
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        clamp_width = (w > MAX_FIELD_W) ? MAX_FIELD_W : w;
    endfunction

endpackage

>>> rtl/core/mbp_field_seq.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer: field sequencer
// Takes one item, works out the escape levels one at a time and hands the
// field bits to the accumulator, MSB first, one per cycle while it is ready.
// ----------------------------------------------------------------------------
module mbp_field_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [mbp_pkg::KIND_W-1:0]    item_kind,
    input  logic [mbp_pkg::VALUE_W-1:0]   item_value,
    input  logic [mbp_pkg::WIDTH_W-1:0]   item_width1,
    input  logic [mbp_pkg::WIDTH_W-1:0]   item_width2,
    input  logic [mbp_pkg::WIDTH_W-1:0]   item_width3,
    output mbp_pkg::mbp_token_t           token,
    input  mbp_pkg::mbp_acc_status_t      acc_status
);
    import mbp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_EMIT  = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          level_reg, level_next;
    logic                cont_reg, cont_next;
    logic                clear_reg, clear_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [VALUE_W-1:0]  ebits_reg, ebits_next;
    logic [WIDTH_W-1:0]  cnt_reg, cnt_next;
    logic [WIDTH_W-1:0]  w1_reg, w1_next;
    logic [WIDTH_W-1:0]  w2_reg, w2_next;
    logic [WIDTH_W-1:0]  w3_reg, w3_next;

    logic [WIDTH_W-1:0]  lvl_w;
    logic [VALUE_W-1:0]  lvl_max;
    logic                lvl_sat;
    logic [WIDTH_W-1:0]  cnt_m1;
    logic                tok_take;

    assign item_ready = (state_reg == ST_IDLE);
    assign cnt_m1     = cnt_reg - 6'd1;
    assign tok_take   = token.valid && acc_status.tok_ready;

    // Width and saturation value of the escape level being loaded.
    always_comb begin
        unique case (level_reg)
            2'd0:    lvl_w = w1_reg;
            2'd1:    lvl_w = w2_reg;
            default: lvl_w = w3_reg;
        endcase
        lvl_max = (lvl_w == MAX_FIELD_W) ? {VALUE_W{1'b1}}
                                         : ~({VALUE_W{1'b1}} << lvl_w[4:0]);
        lvl_sat = (val_reg >= lvl_max);
    end

    always_comb begin
        token          = '0;
        token.clear    = clear_reg;
        token.data_bit = ebits_reg[cnt_m1[4:0]];
        unique case (state_reg)
            ST_EMIT:  token.valid = (cnt_reg != '0);
            ST_ALIGN: begin
                token.valid    = !acc_status.aligned;
                token.data_bit = 1'b0;
            end
            ST_END: begin
                token.valid  = 1'b1;
                token.is_end = 1'b1;
            end
            default:  token.valid = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        cont_next  = cont_reg;
        clear_next = clear_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        ebits_next = ebits_reg;
        cnt_next   = cnt_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        w3_next    = w3_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    val_next   = item_value;
                    ebits_next = item_value;
                    w1_next    = clamp_width(item_width1);
                    w2_next    = clamp_width(item_width2);
                    w3_next    = clamp_width(item_width3);
                    cnt_next   = clamp_width(item_width1);
                    level_next = 2'd0;
                    cont_next  = 1'b0;
                    clear_next = (item_kind == KIND_RESET);
                    unique case (item_kind)
                        KIND_WRITE:  state_next = ST_EMIT;
                        KIND_ESCAPE: state_next = ST_LOAD;
                        KIND_ALIGN:  state_next = ST_ALIGN;
                        default:     state_next = ST_END;
                    endcase
                end
            end
            ST_LOAD: begin
                ebits_next = lvl_sat ? lvl_max : val_reg;
                rem_next   = val_reg - lvl_max;
                cnt_next   = lvl_w;
                cont_next  = lvl_sat && (level_reg != 2'd2);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cnt_reg == '0) begin
                    if (cont_reg) begin
                        val_next   = rem_reg;
                        level_next = level_reg + 2'd1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_END;
                    end
                end else if (tok_take) begin
                    cnt_next = cnt_m1;
                end
            end
            ST_ALIGN: begin
                if (acc_status.aligned) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (tok_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            level_reg <= 2'd0;
            cont_reg  <= 1'b0;
            clear_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            cont_reg  <= cont_next;
            clear_reg <= clear_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        ebits_reg <= ebits_next;
        cnt_reg   <= cnt_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        w3_reg    <= w3_next;
    end

endmodule

>>> rtl/core/mbp_byte_acc.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer: byte accumulator
// Shifts stream bits into the partial byte, counts completed bytes against
// the buffer capacity and drives the registered result channel.
// ----------------------------------------------------------------------------
module mbp_byte_acc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mbp_pkg::CAP_W-1:0]     buffer_bytes,
    input  mbp_pkg::mbp_token_t           token,
    output mbp_pkg::mbp_acc_status_t      acc_status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import mbp_pkg::*;

    logic [7:0]          partial_reg, partial_next;
    logic [3:0]          free_reg, free_next;
    logic [CAP_W-1:0]    bytes_reg, bytes_next;
    logic                ovf_reg, ovf_next;
    logic [BITS_W-1:0]   item_bits_reg, item_bits_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_byte_reg, pend_byte_next;
    logic                pend_ovf_reg, pend_ovf_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_bvalid_reg, out_bvalid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic [BITS_W-1:0]   out_bits_reg, out_bits_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_last_reg, out_last_next;

    logic                can_push;
    logic                completes;
    logic                tok_ready;
    logic [CAP_W-1:0]    cap;
    logic [CAP_W:0]      bytes_inc;
    logic                reach_cap;
    logic [7:0]          shifted;

    assign can_push  = !out_valid_reg || m_tready;
    assign completes = !ovf_reg && (free_reg == 4'd1);
    assign cap       = (buffer_bytes == '0) ? {{(CAP_W-1){1'b0}}, 1'b1} : buffer_bytes;
    assign bytes_inc = {1'b0, bytes_reg} + {{CAP_W{1'b0}}, 1'b1};
    assign reach_cap = (bytes_inc >= {1'b0, cap});
    assign shifted   = {partial_reg[6:0], token.data_bit};

    // A completing bit moves any earlier byte out, so it needs the output free.
    assign tok_ready = token.is_end ? can_push
                                    : !(completes && pend_valid_reg && !can_push);

    assign acc_status.tok_ready = tok_ready;
    assign acc_status.aligned   = (free_reg == BYTE_BITS);

    always_comb begin
        partial_next    = partial_reg;
        free_next       = free_reg;
        bytes_next      = bytes_reg;
        ovf_next        = ovf_reg;
        item_bits_next  = item_bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_bvalid_next = out_bvalid_reg;
        out_byte_next   = out_byte_reg;
        out_bits_next   = out_bits_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        if (token.valid && tok_ready) begin
            if (token.is_end) begin
                out_valid_next  = 1'b1;
                out_bvalid_next = pend_valid_reg;
                out_byte_next   = pend_valid_reg ? pend_byte_reg : 8'd0;
                out_bits_next   = token.clear ? '0 : item_bits_reg;
                out_ovf_next    = token.clear ? 1'b0
                                              : (pend_valid_reg ? pend_ovf_reg : ovf_reg);
                out_last_next   = 1'b1;
                item_bits_next  = '0;
                pend_valid_next = 1'b0;
                if (token.clear) begin
                    partial_next = 8'd0;
                    free_next    = BYTE_BITS;
                    bytes_next   = '0;
                    ovf_next     = 1'b0;
                end
            end else if (!ovf_reg) begin
                item_bits_next = item_bits_reg + 7'd1;
                if (completes) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_bvalid_next = 1'b1;
                        out_byte_next   = pend_byte_reg;
                        out_bits_next   = '0;
                        out_ovf_next    = pend_ovf_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_byte_next  = shifted;
                    pend_ovf_next   = reach_cap;
                    bytes_next      = bytes_inc[CAP_W-1:0];
                    ovf_next        = reach_cap;
                    partial_next    = 8'd0;
                    free_next       = BYTE_BITS;
                end else begin
                    partial_next = shifted;
                    free_next    = free_reg - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg    <= 8'd0;
            free_reg       <= BYTE_BITS;
            bytes_reg      <= '0;
            ovf_reg        <= 1'b0;
            item_bits_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            partial_reg    <= partial_next;
            free_reg       <= free_next;
            bytes_reg      <= bytes_next;
            ovf_reg        <= ovf_next;
            item_bits_reg  <= item_bits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg  <= pend_byte_next;
        pend_ovf_reg   <= pend_ovf_next;
        out_bvalid_reg <= out_bvalid_next;
        out_byte_reg   <= out_byte_next;
        out_bits_reg   <= out_bits_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ovf_reg, out_bits_reg, out_byte_reg};
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/msb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer core
// Packs plain and escaped bit fields into a byte stream, first bit in bit 7.
//
// Requests enter on the s_ channel; tuser carries the kind (write, escaped
// write, align, reset). Every completed byte leaves on the m_ channel with
// tuser set; the final result of a request has tlast set and carries the
// number of bits the request wrote. A request that completes no byte gives
// one result with tuser low. The buffer capacity is written on the cfg_w
// channel, which is always ready; the user must write it only while the block
// is idle, as the block itself does not enforce this. A request is accepted,
// then its field bits are sent one at a time with a step after each field,
// each escape level is loaded in its own step, the pad bits of an align are
// sent with a step after them, and the request closes; no new request is
// taken before it closes. The last result shows in the cycle after closing.
// A stalled receiver holds the result register; one more completed byte is
// held behind it, then the bit path waits and s_tready stays low until the
// request closes.
// Reset clears the stream state and the overflow flag and sets the
// capacity to 16777216 bytes.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value[31:0], width1[37:32], width2[43:38],
                                   // width3[49:44], zero fill[55:50]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], bit_count[14:8], overflow[15]
    output logic        m_tuser,   // byte_valid[0]
    output logic        m_tlast,
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [24:0] cfg_wdata
);
    import mbp_pkg::*;

    localparam logic [CAP_W-1:0] CAP_RESET = 25'd16777216;

    logic [CAP_W-1:0]  cap_reg;
    mbp_token_t        token;
    mbp_acc_status_t   acc_status;

    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wvalid) begin
            cap_reg <= cfg_wdata;
        end
    end

    mbp_field_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_kind   (s_tuser),
        .item_value  (s_tdata[31:0]),
        .item_width1 (s_tdata[37:32]),
        .item_width2 (s_tdata[43:38]),
        .item_width3 (s_tdata[49:44]),
        .token       (token),
        .acc_status  (acc_status)
    );

    mbp_byte_acc u_acc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .buffer_bytes (cap_reg),
        .token        (token),
        .acc_status   (acc_status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

>>> rtl/core/mbp_checker.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer: port checker
// Watches the result channel of the core and flags results that break the
// output rules of the block.
// ----------------------------------------------------------------------------
module mbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A result without a byte is always the only and final result of a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("byteless result not final or not zero");

    // The bit count appears on the final result only, and never above 96.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast || m_tdata[14:8] == 7'd0) && (m_tdata[14:8] <= 7'd96))
        else $error("bad bit count on result");

    // Nothing is offered right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind msb_first_bit_packer_core mbp_checker u_mbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/msb_first_bit_packer_core_tb.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer core testbench
// Sends plain writes, escaped writes, align and reset requests on the s_
// channel and checks every byte on the m_ channel against a packing model
// kept inside the testbench. The buffer capacity is moved through several
// settings, both sides idle at random, and one long receiver stall fills
// the block until it stops taking requests.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbp_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic [6:0] bit_count;
        logic       overflow;
        logic       last;
    } pack_result_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata    = '0;   // value[31:0], width1[37:32], width2[43:38],
                                    // width3[49:44], zero fill[55:50]
    logic [1:0]  s_tuser    = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;           // out_byte[7:0], bit_count[14:8], overflow[15]
    logic        m_tuser;           // byte_valid[0]
    logic        m_tlast;
    logic        cfg_wvalid = 1'b0;
    logic        cfg_wready;
    logic [24:0] cfg_wdata  = '0;

    // Packing model state.
    logic [24:0] capacity_bytes;
    logic [7:0]  partial;
    logic [3:0]  free_bits;
    logic [31:0] bytes_done;
    logic [31:0] total_bits;
    logic        ovf_flag;
    logic [6:0]  item_bit_count;
    pack_result_t item_results[$];
    pack_result_t expected_bytes[$];

    int mismatches     = 0;
    bit steady         = 1'b0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;

    msb_first_bit_packer_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [5:0] sat_width(input logic [5:0] w);
        return (w > 6'd32) ? 6'd32 : w;
    endfunction

    function automatic logic [31:0] level_limit(input logic [5:0] w);
        logic [32:0] t;
        t = (33'd1 << w) - 33'd1;
        return t[31:0];
    endfunction

    task automatic clear_stream();
        partial    = '0;
        free_bits  = 4'd8;
        bytes_done = '0;
        total_bits = '0;
        ovf_flag   = 1'b0;
    endtask

    task automatic shift_in_bits(input logic [31:0] val, input logic [5:0] w);
        int i;
        logic [31:0] eff_cap;
        eff_cap = (capacity_bytes == '0) ? 32'd1 : {7'd0, capacity_bytes};
        for (i = w; i > 0; i--) begin
            if (ovf_flag)
                return;
            free_bits = free_bits - 4'd1;
            partial[free_bits] = val[i-1];
            total_bits++;
            item_bit_count++;
            if (free_bits == 4'd0) begin
                bytes_done++;
                if (bytes_done >= eff_cap)
                    ovf_flag = 1'b1;
                item_results.push_back(pack_result_t'{1'b1, partial, 7'd0, ovf_flag, 1'b0});
                partial   = '0;
                free_bits = 4'd8;
            end
        end
    endtask

    // Works out every result one accepted request causes and queues them.
    task automatic pack_item(input logic [1:0] kind, input logic [31:0] value,
                             input logic [5:0] w1_in, input logic [5:0] w2_in,
                             input logic [5:0] w3_in);
        logic [5:0]  w1, w2, w3;
        logic [31:0] rest, lim, sent;
        pack_result_t tail;
        item_results.delete();
        item_bit_count = '0;
        w1 = sat_width(w1_in);
        w2 = sat_width(w2_in);
        w3 = sat_width(w3_in);
        unique case (kind)
            KIND_RESET: clear_stream();
            KIND_WRITE: shift_in_bits(value, w1);
            KIND_ESCAPE: begin
                // Each saturated level hands the remainder to the next one.
                rest = value;
                lim  = level_limit(w1);
                sent = (rest < lim) ? rest : lim;
                shift_in_bits(sent, w1);
                if (sent == lim) begin
                    rest = rest - sent;
                    lim  = level_limit(w2);
                    sent = (rest < lim) ? rest : lim;
                    shift_in_bits(sent, w2);
                    if (sent == lim) begin
                        rest = rest - sent;
                        lim  = level_limit(w3);
                        sent = (rest < lim) ? rest : lim;
                        shift_in_bits(sent, w3);
                    end
                end
            end
            KIND_ALIGN: begin
                if (free_bits < 4'd8)
                    shift_in_bits(32'd0, {2'b00, free_bits});
            end
            default: ;
        endcase
        if (item_results.size() == 0)
            item_results.push_back(pack_result_t'{1'b0, 8'd0, 7'd0, ovf_flag, 1'b0});
        tail = item_results.pop_back();
        tail.bit_count = item_bit_count;
        tail.last = 1'b1;
        item_results.push_back(tail);
        foreach (item_results[j])
            expected_bytes.push_back(item_results[j]);
    endtask

    // Valid is only lowered on an idle cycle, so a back-to-back request
    // never sees two assignments to s_tvalid in one time step.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] value,
                             input logic [5:0] w1, input logic [5:0] w2,
                             input logic [5:0] w3);
        while (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, w3, w2, w1, value};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pack_item(kind, value, w1, w2, w3);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [24:0] bytes);
        drain();
        cfg_wvalid <= 1'b1;
        cfg_wdata  <= bytes;
        @(posedge aclk);
        while (!cfg_wready)
            @(posedge aclk);
        cfg_wvalid <= 1'b0;
        capacity_bytes = bytes;
    endtask

    function automatic logic [5:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 6'($urandom_range(12));
        else if (r < 92)
            return 6'($urandom_range(32, 13));
        else
            return 6'($urandom_range(63, 33));
    endfunction

    task automatic random_item(input int reset_pct);
        int r;
        logic [1:0]  k;
        logic [31:0] v;
        logic [5:0]  a, b, c;
        r = $urandom_range(99);
        if (r < reset_pct)
            k = KIND_RESET;
        else if (r < reset_pct + 15)
            k = KIND_ALIGN;
        else if (r < reset_pct + 55)
            k = KIND_ESCAPE;
        else
            k = KIND_WRITE;
        a = pick_width();
        b = pick_width();
        c = pick_width();
        r = $urandom_range(3);
        if (r < 2)
            v = $urandom();
        else if (r == 2)
            v = $urandom_range(255);
        else
            // Lands near the sum of the level maximums, so escapes go deep.
            v = level_limit(sat_width(a)) + level_limit(sat_width(b)) + $urandom_range(2);
        send_item(k, v, a, b, c);
    endtask

    task automatic test_plain_writes();
        send_item(KIND_WRITE, 32'h0000_0001, 6'd0, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h0000_0001, 6'd1, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h0000_00A5, 6'd8, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'hFFFF_FFFF, 6'd32, 6'd63, 6'd63);
        send_item(KIND_WRITE, 32'h5A5A_C3C3, 6'd63, 6'd0, 6'd0);
    endtask

    task automatic test_escaped_writes();
        send_item(KIND_ESCAPE, 32'd3, 6'd4, 6'd4, 6'd4);
        send_item(KIND_ESCAPE, 32'd7, 6'd3, 6'd5, 6'd2);
        send_item(KIND_ESCAPE, 32'd40, 6'd3, 6'd4, 6'd6);
        send_item(KIND_ESCAPE, 32'd5, 6'd0, 6'd0, 6'd3);
        send_item(KIND_ESCAPE, 32'hFFFF_FFFF, 6'd31, 6'd31, 6'd32);
        send_item(KIND_ESCAPE, 32'hFFFF_FFFF, 6'd32, 6'd40, 6'd0);
    endtask

    task automatic test_align_and_reset();
        send_item(KIND_ALIGN, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63);
        send_item(KIND_WRITE, 32'd5, 6'd3, 6'd0, 6'd0);
        send_item(KIND_ALIGN, 32'd0, 6'd0, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'd1, 6'd5, 6'd0, 6'd0);
        send_item(KIND_RESET, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63);
    endtask

    task automatic test_capacity_limits();
        write_capacity(25'd3);
        send_item(KIND_WRITE, 32'h0000_BEEF, 6'd16, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h000A_BCDE, 6'd20, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h0000_00FF, 6'd8, 6'd0, 6'd0);
        send_item(KIND_ESCAPE, 32'd100, 6'd2, 6'd2, 6'd2);
        send_item(KIND_ALIGN, 32'd0, 6'd0, 6'd0, 6'd0);
        send_item(KIND_RESET, 32'd0, 6'd0, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h1234_5678, 6'd32, 6'd0, 6'd0);
        write_capacity(25'd0);
        send_item(KIND_RESET, 32'd0, 6'd0, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'h0000_01FF, 6'd9, 6'd0, 6'd0);
        write_capacity(25'h1FF_FFFF);
        send_item(KIND_RESET, 32'd0, 6'd0, 6'd0, 6'd0);
        send_item(KIND_WRITE, 32'hC001_D00D, 6'd32, 6'd0, 6'd0);
        write_capacity(25'd16777216);
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 130; n++) begin
            steady = (n >= 50 && n < 90);
            random_item(4);
        end
        steady = 1'b0;
    endtask

    task automatic test_receiver_stall();
        stall_requests++;
        for (int n = 0; n < 40; n++)
            random_item(4);
    endtask

    task automatic test_small_capacity();
        for (int p = 0; p < 2; p++) begin
            write_capacity(25'($urandom_range(40, 1)));
            send_item(KIND_RESET, 32'd0, 6'd0, 6'd0, 6'd0);
            for (int n = 0; n < 50; n++)
                random_item(12);
        end
        write_capacity(25'd16777216);
    endtask

    // Receiver: random ready, with one long hold-off on request.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left   <= STALL_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 19);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        pack_result_t want;
        pack_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = pack_result_t'{m_tuser, m_tdata[7:0], m_tdata[14:8], m_tdata[15], m_tlast};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: valid=%0b byte=%02h bits=%0d ovf=%0b last=%0b",
                             got.byte_valid, got.out_byte, got.bit_count, got.overflow,
                             got.last);
            end else begin
                want = expected_bytes.pop_front();
                if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
                    got.bit_count !== want.bit_count ||
                    got.overflow !== want.overflow || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected valid=%0b byte=%02h bits=%0d ovf=%0b last=%0b",
                                 want.byte_valid, want.out_byte, want.bit_count,
                                 want.overflow, want.last);
                        $display("          got      valid=%0b byte=%02h bits=%0d ovf=%0b last=%0b",
                                 got.byte_valid, got.out_byte, got.bit_count,
                                 got.overflow, got.last);
                    end
                end
            end
        end
    end

    initial begin
        capacity_bytes = 25'd16777216;
        clear_stream();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_writes();
        test_escaped_writes();
        test_align_and_reset();
        test_capacity_limits();
        test_random_stream();
        test_receiver_stall();
        test_small_capacity();

        drain();
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("msb_first_bit_packer_core_tb OK");
        end else begin
            $display("msb_first_bit_packer_core_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("msb_first_bit_packer_core_tb NOT OK");
        $finish;
    end

endmodule
